/* hw/rtl/hmsc_pkg.sv */
// ----------------------------------------------------------------------------
// hmsc_pkg
// Shared types and constants of the hex-mask signature compiler.
// ----------------------------------------------------------------------------
package hmsc_pkg;

  localparam int CountBits  = 16;
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;
  localparam int OutDataBits = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgEscape   = 3'd0,
    CfgWildcard = 3'd1,
    CfgAnd      = 3'd2,
    CfgOr       = 3'd3,
    CfgRange    = 3'd4,
    CfgBufSize  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StSyntax   = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PhIdle  = 4'd0,
    PhStar  = 4'd1,
    PhWin   = 4'd2,
    PhOp    = 4'd3,
    PhMhi   = 4'd4,
    PhMlo   = 4'd5,
    PhDelim = 4'd6,
    PhVhi   = 4'd7,
    PhVlo   = 4'd8,
    PhClose = 4'd9,
    PhHexlo = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    OpAnd   = 2'd0,
    OpOr    = 2'd1,
    OpRange = 2'd2
  } cond_op_e;

  // One queued unit of work: up to four raw bytes, then an optional status.
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            has_status;
    logic            status_err;
  } entry_t;

  // Condition and wildcard codes seen by the front end.
  typedef struct packed {
    logic [7:0] escape_code;
    logic [7:0] wildcard_code;
    logic [7:0] and_code;
    logic [7:0] or_code;
    logic [7:0] range_code;
  } codes_t;

  // Returns 0..15 for a hex digit, 16 otherwise.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h61 + 8'd10);
    return r;
  endfunction

endpackage

/* hw/rtl/hmsc_front.sv */
// ----------------------------------------------------------------------------
// hmsc_front
// Token parser: takes one character per transfer and produces queue entries
// holding the raw signature bytes of each token and the closing status.
// ----------------------------------------------------------------------------
module hmsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  input  hmsc_pkg::codes_t    codes_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output hmsc_pkg::entry_t    entry_o
);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChRbr   = 8'h5D;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChBar   = 8'h7C;
  localparam logic [7:0] ChRup   = 8'h52;
  localparam logic [7:0] ChRlo   = 8'h72;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChDash  = 8'h2D;

  hmsc_pkg::phase_e   phase_q, phase_d;
  logic [3:0]         fn_q, fn_d;
  logic [7:0]         nmask_q, nmask_d;
  hmsc_pkg::cond_op_e op_q, op_d;
  logic [7:0]         cmask_q, cmask_d;
  logic [16:0]        acc_q, acc_d;
  logic               err_q, err_d;
  logic               fm_q, fm_d;

  logic               accept;
  logic [4:0]         d;
  logic [20:0]        acc_wide;
  logic [7:0]         m, v;
  logic               do_start;
  hmsc_pkg::entry_t   ent;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign d          = hmsc_pkg::hex_val(ch_i);
  assign acc_wide   = {acc_q, 4'b0000} + {17'b0, d[3:0]};

  always_comb begin
    phase_d  = phase_q;
    fn_d     = fn_q;
    nmask_d  = nmask_q;
    op_d     = op_q;
    cmask_d  = cmask_q;
    acc_d    = acc_q;
    err_d    = err_q;
    fm_d     = fm_q;
    do_start = 1'b0;
    m        = nmask_q;
    v        = {fn_q, d[3:0]};
    ent      = '0;

    if (!err_q) begin
      case (phase_q)
        hmsc_pkg::PhIdle: begin
          do_start = 1'b1;
        end
        hmsc_pkg::PhStar: begin
          if (ch_i == ChLbr) begin
            if (last_i) begin
              err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
            end else begin
              acc_d = '0; phase_d = hmsc_pkg::PhWin;
            end
          end else begin
            ent.nbytes = 3'd4;
            ent.bytes  = {8'h01, 8'h00, codes_i.wildcard_code, codes_i.escape_code};
            phase_d    = hmsc_pkg::PhIdle;
            do_start   = 1'b1;
          end
        end
        hmsc_pkg::PhWin: begin
          if (ch_i == ChRbr) begin
            if (acc_q == '0 || acc_q > 17'hFFFF) begin
              err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
            end else begin
              ent.nbytes = 3'd4;
              ent.bytes  = {acc_q[15:8], acc_q[7:0], codes_i.wildcard_code,
                            codes_i.escape_code};
              phase_d    = hmsc_pkg::PhIdle;
            end
          end else if (last_i || d[4]) begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end else if (acc_wide > 21'hFFFF) begin
            acc_d = 17'h10000;
          end else begin
            acc_d = acc_wide[16:0];
          end
        end
        hmsc_pkg::PhOp: begin
          phase_d = hmsc_pkg::PhMhi;
          if (last_i) begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end else if (ch_i == ChAmp) begin
            op_d = hmsc_pkg::OpAnd;
          end else if (ch_i == ChBar) begin
            op_d = hmsc_pkg::OpOr;
          end else if (ch_i == ChRup || ch_i == ChRlo) begin
            op_d = hmsc_pkg::OpRange;
          end else begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end
        end
        hmsc_pkg::PhMhi, hmsc_pkg::PhVhi: begin
          if (last_i || d[4]) begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end else begin
            fn_d    = d[3:0];
            phase_d = (phase_q == hmsc_pkg::PhMhi) ? hmsc_pkg::PhMlo : hmsc_pkg::PhVlo;
          end
        end
        hmsc_pkg::PhMlo: begin
          if (last_i || d[4]) begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end else begin
            cmask_d = {fn_q, d[3:0]};
            phase_d = hmsc_pkg::PhDelim;
          end
        end
        hmsc_pkg::PhDelim: begin
          if (last_i || (ch_i != ChEq && ch_i != ChDash)) begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end else begin
            phase_d = hmsc_pkg::PhVhi;
          end
        end
        hmsc_pkg::PhVlo: begin
          m = cmask_q;
          if (last_i || d[4]) begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end else begin
            case (op_q)
              hmsc_pkg::OpAnd: begin
                if ((v & ~m) != 8'h00) begin
                  err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
                end else begin
                  ent.nbytes = 3'd4;
                  ent.bytes  = {v, m, codes_i.and_code, codes_i.escape_code};
                  phase_d    = hmsc_pkg::PhClose;
                end
              end
              hmsc_pkg::OpOr: begin
                if ((v & m) != m) begin
                  err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
                end else begin
                  ent.nbytes = 3'd4;
                  ent.bytes  = {v, m, codes_i.or_code, codes_i.escape_code};
                  phase_d    = hmsc_pkg::PhClose;
                end
              end
              default: begin
                if (m >= v) begin
                  err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
                end else begin
                  ent.nbytes = 3'd4;
                  ent.bytes  = {v, m, codes_i.range_code, codes_i.escape_code};
                  phase_d    = hmsc_pkg::PhClose;
                end
              end
            endcase
          end
        end
        hmsc_pkg::PhClose: begin
          phase_d = hmsc_pkg::PhIdle;
          if (ch_i != ChRbr) err_d = 1'b1;
        end
        hmsc_pkg::PhHexlo: begin
          if (ch_i == ChQuest) begin
            m = nmask_q & 8'hF0;
            v = {fn_q, 4'h0};
          end
          if (ch_i != ChQuest && d[4]) begin
            err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
          end else begin
            if (m != 8'hFF) begin
              ent.nbytes = 3'd4;
              ent.bytes  = {v, m, codes_i.and_code, codes_i.escape_code};
            end else begin
              ent.nbytes = (v == codes_i.escape_code) ? 3'd2 : 3'd1;
              ent.bytes  = {8'h00, 8'h00, v, v};
            end
            fm_d    = (m == 8'h00);
            phase_d = hmsc_pkg::PhIdle;
          end
        end
        default: begin
          phase_d = hmsc_pkg::PhIdle;
        end
      endcase

      if (do_start && !last_i && ch_i != ChSpace && ch_i != ChTab) begin
        fm_d = 1'b0;
        if (ch_i == ChStar) begin
          phase_d = hmsc_pkg::PhStar;
        end else if (ch_i == ChLbr) begin
          phase_d = hmsc_pkg::PhOp;
        end else if (ch_i == ChQuest) begin
          nmask_d = 8'h0F; fn_d = 4'h0; phase_d = hmsc_pkg::PhHexlo;
        end else if (d[4]) begin
          err_d = 1'b1; phase_d = hmsc_pkg::PhIdle;
        end else begin
          nmask_d = 8'hFF; fn_d = d[3:0]; phase_d = hmsc_pkg::PhHexlo;
        end
      end
    end

    if (last_i) begin
      ent.has_status = 1'b1;
      ent.status_err = err_d || fm_d;
      phase_d = hmsc_pkg::PhIdle;
      fn_d    = '0;
      nmask_d = 8'hFF;
      op_d    = hmsc_pkg::OpAnd;
      cmask_d = '0;
      acc_d   = '0;
      err_d   = 1'b0;
      fm_d    = 1'b0;
    end
  end

  assign push_o  = accept && (ent.nbytes != 3'd0 || ent.has_status);
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hmsc_pkg::PhIdle;
      fn_q    <= '0;
      nmask_q <= 8'hFF;
      op_q    <= hmsc_pkg::OpAnd;
      cmask_q <= '0;
      acc_q   <= '0;
      err_q   <= 1'b0;
      fm_q    <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      fn_q    <= fn_d;
      nmask_q <= nmask_d;
      op_q    <= op_d;
      cmask_q <= cmask_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
      fm_q    <= fm_d;
    end
  end

`ifndef SYNTH
  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> phase_q == hmsc_pkg::PhIdle) else $error("error with token open");
  a_acc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= 17'h10000) else $error("window accumulator beyond saturation");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (phase_q == hmsc_pkg::PhIdle && !err_q && !fm_q))
    else $error("mask state not cleared after last character");
`endif

endmodule

/* hw/rtl/hmsc_queue.sv */
// ----------------------------------------------------------------------------
// hmsc_queue
// Small FIFO of token entries between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module hmsc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hmsc_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output hmsc_pkg::entry_t  head_o
);

  hmsc_pkg::entry_t                mem_q [hmsc_pkg::QueueDepth];
  logic [hmsc_pkg::QPtrBits-1:0]   wr_q, rd_q;
  logic [hmsc_pkg::QCntBits-1:0]   cnt_q;

  assign full_o       = cnt_q == hmsc_pkg::QCntBits'(hmsc_pkg::QueueDepth);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hmsc_pkg::QCntBits'(hmsc_pkg::QueueDepth)) else $error("queue count out of range");
`endif

endmodule

/* hw/rtl/hmsc_back.sv */
// ----------------------------------------------------------------------------
// hmsc_back
// Byte emitter: walks the bytes of each queued entry, applies the buffer
// capacity, counts the signature length and issues the status item.
// ----------------------------------------------------------------------------
module hmsc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               head_valid_i,
  input  hmsc_pkg::entry_t                   head_i,
  input  logic [15:0]                        buffer_size_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [hmsc_pkg::OutDataBits-1:0]   m_axis_tdata,
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int ExtW = 33;
  localparam logic [hmsc_pkg::CountBits-1:0] CntMax = '1;

  logic [hmsc_pkg::CountBits-1:0] cnt_q, cnt_d;
  logic                           ovf_q, ovf_d;
  logic [2:0]                     idx_q, idx_d;
  logic                           vld_q, vld_d;
  logic                           user_q, user_d;
  logic [7:0]                     byte_q, byte_d;
  hmsc_pkg::status_e              st_q, st_d;
  logic [15:0]                    len_q, len_d;

  logic                           advance, at_status, room;
  logic [ExtW-1:0]                cnt_ext;
  logic [15:0]                    len_sat;

  assign advance   = head_valid_i && (!vld_q || m_axis_tready);
  assign at_status = idx_q == head_i.nbytes;
  assign cnt_ext   = ExtW'(cnt_q);
  assign room      = (cnt_ext < ExtW'(buffer_size_i)) && (cnt_q != CntMax);
  assign len_sat   = (cnt_ext > ExtW'(16'hFFFF)) ? 16'hFFFF : 16'(cnt_ext);

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    idx_d  = idx_q;
    vld_d  = vld_q && !m_axis_tready;
    user_d = user_q;
    byte_d = byte_q;
    st_d   = st_q;
    len_d  = len_q;
    pop_o  = 1'b0;
    if (advance) begin
      if (!at_status) begin
        if (room) begin
          vld_d  = 1'b1;
          user_d = 1'b0;
          byte_d = head_i.bytes[idx_q[1:0]];
          st_d   = hmsc_pkg::StOk;
          len_d  = '0;
        end else begin
          ovf_d = 1'b1;
        end
        if (cnt_q != CntMax) cnt_d = cnt_q + 1'b1;
        if (idx_q + 3'd1 == head_i.nbytes && !head_i.has_status) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end else begin
        vld_d  = 1'b1;
        user_d = 1'b1;
        byte_d = '0;
        len_d  = len_sat;
        if (head_i.status_err) st_d = hmsc_pkg::StSyntax;
        else if (ovf_q)        st_d = hmsc_pkg::StOverflow;
        else                   st_d = hmsc_pkg::StOk;
        cnt_d  = '0;
        ovf_d  = 1'b0;
        idx_d  = '0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    user_q <= user_d;
    byte_q <= byte_d;
    st_q   <= st_d;
    len_q  <= len_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = user_q;
  assign m_axis_tdata  = {6'b0, len_q, st_q, byte_q};

`ifndef SYNTH
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == '0) else $error("byte index left over with empty queue");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.nbytes) else $error("byte index past entry");
  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && at_status) |=> (cnt_q == '0 && !ovf_q && m_axis_tvalid && m_axis_tuser))
    else $error("status transfer did not close the mask");
`endif

endmodule

/* hw/rtl/hex_mask_signature_compiler.sv */
// ----------------------------------------------------------------------------
// hex_mask_signature_compiler
// Compiles hex-mask text, one character per transfer, into escaped
// signature bytes followed by a status item.
//
// Input stream: s_axis_tdata[7:0] is the character, s_axis_tlast marks the
// last character of a mask. Output stream: m_axis_tuser is 0 on a byte item
// and 1 on the status item; m_axis_tlast is set on the status item.
// Configuration: cfg_we_i writes register cfg_addr_i (0 escape, 1 wildcard,
// 2 and, 3 or, 4 range code, 5 buffer size). The user must write only while
// the block is idle; the block itself does not enforce it. With the queue
// empty, an accepted token is written to the queue, then to the output register.
// Throughput: the parser takes one character per cycle; the emitter sends
// one byte per cycle while the receiver is ready, and a four-entry queue
// between them absorbs the bursts. The parser stalls only when that queue
// is full.
// Reset returns the registers to their defaults and empties the queue and
// output register. When the receiver stalls, the output register holds its
// item, the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module hex_mask_signature_compiler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hmsc_pkg::CfgIdxBits-1:0]      cfg_addr_i,
  input  logic [hmsc_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] ch
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] sig_byte, [9:8] status, [25:10] total_len, [31:26] zero
  output logic [hmsc_pkg::OutDataBits-1:0]     m_axis_tdata,
  output logic                                 m_axis_tuser,  // [0] is_status
  output logic                                 m_axis_tlast
);

  hmsc_pkg::codes_t  codes_q;
  logic [15:0]       bufsz_q;
  logic              q_full, push, pop, head_valid;
  hmsc_pkg::entry_t  push_entry, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.escape_code   <= 8'd0;
      codes_q.wildcard_code <= 8'd1;
      codes_q.and_code      <= 8'd2;
      codes_q.or_code       <= 8'd3;
      codes_q.range_code    <= 8'd4;
      bufsz_q               <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        hmsc_pkg::CfgEscape:   codes_q.escape_code   <= cfg_wdata_i[7:0];
        hmsc_pkg::CfgWildcard: codes_q.wildcard_code <= cfg_wdata_i[7:0];
        hmsc_pkg::CfgAnd:      codes_q.and_code      <= cfg_wdata_i[7:0];
        hmsc_pkg::CfgOr:       codes_q.or_code       <= cfg_wdata_i[7:0];
        hmsc_pkg::CfgRange:    codes_q.range_code    <= cfg_wdata_i[7:0];
        hmsc_pkg::CfgBufSize:  bufsz_q               <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hmsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .ch_i       (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .codes_i    (codes_q),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  hmsc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  hmsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .buffer_size_i (bufsz_q),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hex_mask_signature_compiler. A short table of masks
// covers separators, escape doubling, wildcards, windows, a range condition,
// a token on the final character and a final fully masked pair. Random masks
// then run under several register settings. A local compiler model predicts
// every signature byte and status transfer, and the output monitor checks
// each field. The sender and receiver both throttle at random.
// ----------------------------------------------------------------------------
module tb;
  import hmsc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseChars = 55;
  localparam int NumPhases  = 7;

  typedef struct packed {
    logic       is_status;
    logic [7:0] sig_byte;
    status_e    status;
    logic [15:0] total_len;
  } sig_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    status_e     st;
    logic [15:0] len;
  } dir_row_t;

  localparam dir_row_t DirRows [25] = '{
    '{"A", 1'b1, 1'b1, StOk, 16'd0},      // token on the final character
    '{"?", 1'b0, 1'b0, StOk, 16'd0},
    '{"?", 1'b1, 1'b1, StSyntax, 16'd4},  // final fully masked pair
    '{"0", 1'b0, 1'b0, StOk, 16'd0},
    '{"0", 1'b0, 1'b0, StOk, 16'd0},
    '{"F", 1'b0, 1'b0, StOk, 16'd0},
    '{"f", 1'b0, 1'b0, StOk, 16'd0},
    '{"*", 1'b0, 1'b0, StOk, 16'd0},
    '{"[", 1'b0, 1'b0, StOk, 16'd0},
    '{"F", 1'b0, 1'b0, StOk, 16'd0},
    '{"F", 1'b0, 1'b0, StOk, 16'd0},
    '{"F", 1'b0, 1'b0, StOk, 16'd0},
    '{"F", 1'b0, 1'b0, StOk, 16'd0},
    '{"]", 1'b0, 1'b0, StOk, 16'd0},
    '{"\t", 1'b0, 1'b0, StOk, 16'd0},
    '{"[", 1'b0, 1'b0, StOk, 16'd0},
    '{"R", 1'b0, 1'b0, StOk, 16'd0},
    '{"0", 1'b0, 1'b0, StOk, 16'd0},
    '{"0", 1'b0, 1'b0, StOk, 16'd0},
    '{"-", 1'b0, 1'b0, StOk, 16'd0},
    '{"f", 1'b0, 1'b0, StOk, 16'd0},
    '{"f", 1'b0, 1'b0, StOk, 16'd0},
    '{"]", 1'b0, 1'b0, StOk, 16'd0},
    '{"*", 1'b0, 1'b0, StOk, 16'd0},
    '{"X", 1'b1, 1'b0, StOk, 16'd0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_addr_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [7:0] ch
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;   // [7:0] sig_byte, [9:8] status, [25:10] total_len
  logic                   m_axis_tuser;   // [0] is_status
  logic                   m_axis_tlast;

  hex_mask_signature_compiler u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // register copies
  logic [7:0]  esc_code, wild_code, and_code, or_code, range_code;
  logic [15:0] buf_size;

  // compiler state
  phase_e      parse_phase;
  logic [3:0]  hi_nib;
  logic [7:0]  nib_mask;
  cond_op_e    cop;
  logic [7:0]  cmask;
  int          win_acc;
  logic [15:0] out_count;
  logic        error_seen, fully_masked, overflowed;

  sig_item_t   sig_items_due[$];
  logic [7:0]  mask_text[$];
  int          cycle_cnt = 0;
  int          mismatches = 0;
  int          burst_left = 0;
  int          phase_chars = 0;

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'd16;
  endfunction

  task automatic clear_mask_state();
    parse_phase = PhIdle;
    hi_nib = 4'h0;
    nib_mask = 8'hFF;
    cop = OpAnd;
    cmask = 8'h00;
    win_acc = 0;
    out_count = 16'h0000;
    error_seen = 1'b0;
    fully_masked = 1'b0;
    overflowed = 1'b0;
  endtask

  task automatic put_sig(logic [7:0] b);
    if (out_count < buf_size) sig_items_due.push_back('{1'b0, b, StOk, 16'h0000});
    else overflowed = 1'b1;
    if (out_count != 16'hFFFF) out_count++;
  endtask

  task automatic put_cond(logic [7:0] code, logic [7:0] m, logic [7:0] v);
    put_sig(esc_code);
    put_sig(code);
    put_sig(m);
    put_sig(v);
  endtask

  task automatic abort_mask();
    error_seen = 1'b1;
    parse_phase = PhIdle;
  endtask

  task automatic take_token(logic [7:0] c, logic last);
    logic [4:0] d;
    if (last || c == " " || c == "\t") return;
    fully_masked = 1'b0;
    d = nibble_of(c);
    if (c == "*") begin
      parse_phase = PhStar;
    end else if (c == "[") begin
      parse_phase = PhOp;
    end else if (c == "?") begin
      nib_mask = 8'h0F;
      hi_nib = 4'h0;
      parse_phase = PhHexlo;
    end else if (d[4]) begin
      abort_mask();
    end else begin
      nib_mask = 8'hFF;
      hi_nib = d[3:0];
      parse_phase = PhHexlo;
    end
  endtask

  task automatic compile_char(logic [7:0] c, logic last);
    logic [4:0] d;
    logic [7:0] m, v;
    d = nibble_of(c);
    case (parse_phase)
      PhIdle: take_token(c, last);
      PhStar: begin
        if (c == "[") begin
          if (last) abort_mask();
          else begin
            win_acc = 0;
            parse_phase = PhWin;
          end
        end else begin
          put_cond(wild_code, 8'h00, 8'h01);
          parse_phase = PhIdle;
          take_token(c, last);
        end
      end
      PhWin: begin
        if (c == "]") begin
          if (win_acc == 0 || win_acc > 'hFFFF) abort_mask();
          else begin
            put_cond(wild_code, win_acc[7:0], win_acc[15:8]);
            parse_phase = PhIdle;
          end
        end else if (last || d[4]) begin
          abort_mask();
        end else begin
          win_acc = (win_acc << 4) + int'(d);
          if (win_acc > 'hFFFF) win_acc = 'h10000;
        end
      end
      PhOp: begin
        if (last) abort_mask();
        else if (c == "&") begin
          cop = OpAnd;
          parse_phase = PhMhi;
        end else if (c == "|") begin
          cop = OpOr;
          parse_phase = PhMhi;
        end else if (c == "R" || c == "r") begin
          cop = OpRange;
          parse_phase = PhMhi;
        end else abort_mask();
      end
      PhMhi, PhVhi: begin
        if (last || d[4]) abort_mask();
        else begin
          hi_nib = d[3:0];
          if (parse_phase == PhMhi) parse_phase = PhMlo;
          else parse_phase = PhVlo;
        end
      end
      PhMlo: begin
        if (last || d[4]) abort_mask();
        else begin
          cmask = {hi_nib, d[3:0]};
          parse_phase = PhDelim;
        end
      end
      PhDelim: begin
        if (last || (c != "=" && c != "-")) abort_mask();
        else parse_phase = PhVhi;
      end
      PhVlo: begin
        if (last || d[4]) abort_mask();
        else begin
          v = {hi_nib, d[3:0]};
          m = cmask;
          case (cop)
            OpAnd: begin
              if ((v & ~m) != 8'h00) abort_mask();
              else begin
                put_cond(and_code, m, v);
                parse_phase = PhClose;
              end
            end
            OpOr: begin
              if ((v & m) != m) abort_mask();
              else begin
                put_cond(or_code, m, v);
                parse_phase = PhClose;
              end
            end
            default: begin
              if (m >= v) abort_mask();
              else begin
                put_cond(range_code, m, v);
                parse_phase = PhClose;
              end
            end
          endcase
        end
      end
      PhClose: begin
        if (c != "]") abort_mask();
        else parse_phase = PhIdle;
      end
      PhHexlo: begin
        if (c == "?") begin
          m = nib_mask & 8'hF0;
          d = 5'd0;
        end else begin
          m = nib_mask;
        end
        if (d[4]) abort_mask();
        else begin
          v = {hi_nib, d[3:0]};
          if (m != 8'hFF) put_cond(and_code, m, v);
          else begin
            put_sig(v);
            if (v == esc_code) put_sig(v);
          end
          fully_masked = (m == 8'h00);
          parse_phase = PhIdle;
        end
      end
      default: parse_phase = PhIdle;
    endcase
  endtask

  task automatic compile_step(logic [7:0] c, logic last);
    status_e st;
    if (!error_seen) compile_char(c, last);
    if (last) begin
      st = StOk;
      if (error_seen || fully_masked) st = StSyntax;
      else if (overflowed) st = StOverflow;
      sig_items_due.push_back('{1'b1, 8'h00, st, out_count});
      clear_mask_state();
    end
  endtask

  task automatic feed_char(logic [7:0] c, logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    compile_step(c, last);
    burst_left--;
    phase_chars++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sig_items_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgEscape:   esc_code   = val[7:0];
      CfgWildcard: wild_code  = val[7:0];
      CfgAnd:      and_code   = val[7:0];
      CfgOr:       or_code    = val[7:0];
      CfgRange:    range_code = val[7:0];
      CfgBufSize:  buf_size   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // upper byte of the 8-bit registers carries junk that must be ignored
  task automatic load_regs(logic [7:0] e, logic [7:0] w, logic [7:0] a,
                           logic [7:0] o, logic [7:0] r, logic [15:0] bs);
    set_reg(CfgEscape,   {8'($urandom), e});
    set_reg(CfgWildcard, {8'($urandom), w});
    set_reg(CfgAnd,      {8'($urandom), a});
    set_reg(CfgOr,       {8'($urandom), o});
    set_reg(CfgRange,    {8'($urandom), r});
    set_reg(CfgBufSize,  bs);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] hex_digit(int unsigned v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
  endfunction

  task automatic add_hex_text(logic [7:0] b);
    mask_text.push_back(hex_digit(b[7:4]));
    mask_text.push_back(hex_digit(b[3:0]));
  endtask

  task automatic build_mask();
    int         kind, sel, ndig;
    logic [7:0] m, v, opc;
    mask_text.delete();
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        add_hex_text(($urandom_range(0, 3) == 0) ? esc_code : 8'($urandom));
      end else if (kind < 37) begin
        case ($urandom_range(0, 2))
          0: begin
            mask_text.push_back("?");
            mask_text.push_back(hex_digit($urandom_range(0, 15)));
          end
          1: begin
            mask_text.push_back(hex_digit($urandom_range(0, 15)));
            mask_text.push_back("?");
          end
          default: begin
            mask_text.push_back("?");
            mask_text.push_back("?");
          end
        endcase
      end else if (kind < 47) begin
        mask_text.push_back("*");
      end else if (kind < 62) begin
        mask_text.push_back("*");
        mask_text.push_back("[");
        sel = $urandom_range(0, 19);
        if (sel == 0) mask_text.push_back("0");
        else begin
          ndig = (sel == 1) ? 5 : $urandom_range(1, 4);
          repeat (ndig) mask_text.push_back(hex_digit($urandom_range(0, 15)));
        end
        if (sel == 2) mask_text.push_back($urandom_range(0, 1) ? "g" : " ");
        if (sel != 3) mask_text.push_back("]");
      end else if (kind < 90) begin
        case ($urandom_range(0, 3))
          0: opc = "&";
          1: opc = "|";
          2: opc = "R";
          default: opc = "r";
        endcase
        m = 8'($urandom);
        if (opc == "&") v = 8'($urandom) & m;
        else if (opc == "|") v = 8'($urandom) | m;
        else begin
          if (m == 8'hFF) m = 8'hFE;
          v = 8'($urandom_range(m + 1, 255));
        end
        sel = $urandom_range(0, 99);
        if (sel < 10) v = 8'($urandom);
        else if (sel < 16) opc = 8'($urandom);
        mask_text.push_back("[");
        mask_text.push_back(opc);
        add_hex_text(m);
        if (sel >= 16 && sel < 21) mask_text.push_back("_");
        else mask_text.push_back($urandom_range(0, 1) ? "=" : "-");
        add_hex_text(v);
        if ($urandom_range(0, 9) != 0) mask_text.push_back("]");
        else mask_text.push_back(8'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: mask_text.push_back(8'h00);
          1: mask_text.push_back(8'hFF);
          default: mask_text.push_back(8'($urandom));
        endcase
      end
      repeat ($urandom_range(0, 2)) mask_text.push_back($urandom_range(0, 1) ? " " : "\t");
    end
    if ($urandom_range(0, 9) < 3) mask_text.push_back(8'($urandom));
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    sig_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sig_items_due.size() == 0) begin
        $error("output transfer with nothing expected: tdata %0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = sig_items_due.pop_front();
        check_field("is_status", want.is_status, m_axis_tuser);
        check_field("sig_byte", want.sig_byte, m_axis_tdata[7:0]);
        check_field("status", want.status, m_axis_tdata[9:8]);
        check_field("total_len", want.total_len, m_axis_tdata[25:10]);
        check_field("last_out", want.is_status, m_axis_tlast);
        check_field("tdata pad", 0, m_axis_tdata[31:26]);
      end
    end
  end

  // receiver stall pattern, mode taken from bits [9:8] of the cycle counter
  always @(posedge clk_i) begin
    case (cycle_cnt[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready <= (cycle_cnt[2:0] == 3'd0);
      default: m_axis_tready <= (cycle_cnt % 5 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [7:0]  e;
    logic [15:0] bs;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CfgEscape;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    esc_code   = 8'h00;
    wild_code  = 8'h01;
    and_code   = 8'h02;
    or_code    = 8'h03;
    range_code = 8'h04;
    buf_size   = 16'hFFFF;
    clear_mask_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      feed_char(DirRows[i].ch, DirRows[i].last);
      if (DirRows[i].typed)
        sig_items_due[sig_items_due.size()-1] = '{1'b1, 8'h00, DirRows[i].st, DirRows[i].len};
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        1: load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        default: begin
          case ($urandom_range(0, 2))
            0: e = 8'h00;
            1: e = 8'hFF;
            default: e = 8'($urandom);
          endcase
          case ($urandom_range(0, 3))
            0: bs = 16'($urandom_range(0, 24));
            1: bs = 16'($urandom);
            2: bs = 16'hFFFF;
            default: bs = 16'($urandom_range(25, 80));
          endcase
          load_regs(e, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), bs);
        end
      endcase
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        build_mask();
        foreach (mask_text[i]) feed_char(mask_text[i], i == mask_text.size() - 1);
      end
    end
    drain();

    if (sig_items_due.size() != 0) begin
      $error("%0d expected transfers never arrived", sig_items_due.size());
      mismatches++;
    end
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
